>>> rtl/rrbm_pkg.sv
// Shared types and constants of the ROM and RAM bank mapper.
`timescale 1ns / 1ps
`default_nettype none

package rrbm_pkg;

   // Field widths of the bus access and of the mapped result.
   localparam int ADDR_W   = 16;
   localparam int DATA_W   = 8;
   localparam int MAP_W    = 21;
   localparam int REGION_W = 3;
   localparam int CSR_IDX_W = 8;

   // Widths of the bank registers and of the configured bank counts.
   localparam int ROM_LOW_W   = 5;
   localparam int UPPER_W     = 2;
   localparam int ROM_BANK_W  = ROM_LOW_W + UPPER_W;
   localparam int ROM_CNT_W   = 8;
   localparam int RAM_CNT_W   = 3;

   // Bus address boundaries.
   localparam logic [ADDR_W-1:0] ADDR_ENABLE_HI = 16'h1FFF;
   localparam logic [ADDR_W-1:0] ADDR_LOW_HI    = 16'h3FFF;
   localparam logic [ADDR_W-1:0] ADDR_ROM_SW_LO = 16'h4000;
   localparam logic [ADDR_W-1:0] ADDR_UPPER_HI  = 16'h5FFF;
   localparam logic [ADDR_W-1:0] ADDR_ROM_SW_HI = 16'h7FFF;
   localparam logic [ADDR_W-1:0] ADDR_RAM_LO    = 16'hA000;
   localparam logic [ADDR_W-1:0] ADDR_RAM_HI    = 16'hBFFF;
   localparam logic [ADDR_W-1:0] ADDR_DMA       = 16'hFF46;

   // Data patterns and advanced-mode thresholds.
   localparam logic [3:0]        RAM_ENABLE_KEY = 4'hA;
   localparam logic [DATA_W-1:0] OPEN_BUS_DATA  = 8'hFF;
   localparam logic [ROM_CNT_W-1:0] ADV_MIN_ROM_BANKS = 8'd32;
   localparam logic [RAM_CNT_W-1:0] ADV_MIN_RAM_BANKS = 3'd1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ROM_BANK_COUNT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAM_BANK_COUNT = 8'd1;

   // Access kinds.
   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // Region codes of a result.
   typedef enum logic [REGION_W-1:0] {
      REGION_MAIN     = 3'd0,
      REGION_ROM      = 3'd1,
      REGION_RAM      = 3'd2,
      REGION_RAM_OFF  = 3'd3,
      REGION_CONTROL  = 3'd4,
      REGION_RAM_DROP = 3'd5,
      REGION_DMA      = 3'd6
   } region_type;

   // One bus access.
   typedef struct packed {
      logic              func;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_data;
   } req_payload_type;

   // One result.
   typedef struct packed {
      region_type        region;
      logic [MAP_W-1:0]  mapped_address;
      logic [DATA_W-1:0] forced_data;
      logic              bank_error;
   } rsp_payload_type;

   // Bank controller state.
   typedef struct packed {
      logic                 ram_enabled;
      logic [ROM_LOW_W-1:0] rom_bank_low;
      logic [UPPER_W-1:0]   upper_bank_bits;
      logic                 advanced_mode;
   } bank_state_type;

   // Configuration registers.
   typedef struct packed {
      logic [ROM_CNT_W-1:0] rom_bank_count;
      logic [RAM_CNT_W-1:0] ram_bank_count;
   } bank_cfg_type;

   // State update from the decoder to the bank registers.
   typedef struct packed {
      logic           en;
      bank_state_type next;
   } state_update_type;

endpackage

`default_nettype wire

>>> rtl/rrbm_ifs.sv
// Handshake channel interfaces for requests, results and register writes.
`timescale 1ns / 1ps
`default_nettype none

interface rrbm_req_if
   import rrbm_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              func;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] write_data;

   modport source (output valid, func, address, write_data, input ready);
   modport sink   (input valid, func, address, write_data, output ready);
endinterface

interface rrbm_rsp_if
   import rrbm_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [REGION_W-1:0] region;
   logic [MAP_W-1:0]    mapped_address;
   logic [DATA_W-1:0]   forced_data;
   logic                bank_error;

   modport source (output valid, region, mapped_address, forced_data, bank_error,
                   input ready);
   modport sink   (input valid, region, mapped_address, forced_data, bank_error,
                   output ready);
endinterface

interface rrbm_csr_if
   import rrbm_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DATA_W-1:0]    wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

>>> rtl/rom_ram_bank_mapper_top.sv
// Top level of the ROM and RAM bank mapper: input register, decode, result register.
// The mapper takes one bus access per cycle and returns one result per access: the
// access is captured in an input register, decoded and translated against the current
// bank registers in a single pass, and the result lands in an output register while the
// bank registers take their new values in the same cycle. Accesses therefore stream back
// to back at one per cycle, with the only back-pressure coming from the result channel.
// Register writes on the csr port are always accepted and must be issued while no access
// is in flight.
`timescale 1ns / 1ps
`default_nettype none

module rom_ram_bank_mapper_top
   import rrbm_pkg::*;
#(
   parameter int MAX_ROM_BANKS = 128,
   parameter int MAX_RAM_BANKS = 4
) (
   input  logic        clock,
   input  logic        reset,
   rrbm_req_if.sink    req_bus,
   rrbm_rsp_if.source  rsp_bus,
   rrbm_csr_if.sink    csr_bus
);

   logic             s1_valid_ff;
   logic             s1_valid_in;
   req_payload_type  s1_req_ff;
   logic             out_valid_ff;
   logic             out_valid_in;
   rsp_payload_type  out_rsp_ff;
   logic             s1_adv;
   logic             req_take;
   rsp_payload_type  dec_rsp;
   bank_state_type   dec_next;
   bank_state_type   bank_state;
   bank_cfg_type     bank_cfg;
   state_update_type update;

   // Pipeline flow: stage one moves on when the result register is free or drains.
   assign s1_adv        = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_adv;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign s1_valid_in   = req_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign out_valid_in  = s1_adv ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register captures each accepted beat.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff.func       <= req_bus.func;
         s1_req_ff.address    <= req_bus.address;
         s1_req_ff.write_data <= req_bus.write_data;
      end
   end

   // Result register loads the decoded beat.
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_rsp_ff <= dec_rsp;
      end
   end

   rrbm_decode #(
      .MAX_ROM_BANKS (MAX_ROM_BANKS),
      .MAX_RAM_BANKS (MAX_RAM_BANKS)
   ) u_decode (
      .req        (s1_req_ff),
      .state      (bank_state),
      .cfg        (bank_cfg),
      .rsp        (dec_rsp),
      .next_state (dec_next)
   );

   assign update.en   = s1_adv;
   assign update.next = dec_next;

   rrbm_bank_regs u_bank_regs (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .update  (update),
      .state   (bank_state),
      .cfg     (bank_cfg)
   );

   // Result channel outputs.
   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.region         = out_rsp_ff.region;
   assign rsp_bus.mapped_address = out_rsp_ff.mapped_address;
   assign rsp_bus.forced_data    = out_rsp_ff.forced_data;
   assign rsp_bus.bank_error     = out_rsp_ff.bank_error;

   // The low ROM bank never holds zero.
   a_low_bank_nonzero: assert property (@(posedge clock) disable iff (reset)
      bank_state.rom_bank_low != '0)
      else $error("low ROM bank register holds zero");

   // Bank state only moves when a beat passes through the decoder.
   a_state_quiet: assert property (@(posedge clock) disable iff (reset)
      !s1_adv |=> $stable(bank_state))
      else $error("bank state changed without a beat");

   // A bank error is only reported for a control write.
   a_error_on_control: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.bank_error |-> rsp_bus.region == REGION_CONTROL)
      else $error("bank error outside a control write");

   // Open-bus data appears only on a disabled RAM read.
   a_forced_data: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.forced_data != '0) |-> rsp_bus.region == REGION_RAM_OFF)
      else $error("forced data outside a disabled RAM read");

endmodule

`default_nettype wire

>>> rtl/rrbm_decode.sv
// Address decode, bank translation and bank register update logic.
`timescale 1ns / 1ps
`default_nettype none

module rrbm_decode
   import rrbm_pkg::*;
#(
   parameter int MAX_ROM_BANKS = 128,
   parameter int MAX_RAM_BANKS = 4
) (
   input  req_payload_type  req,
   input  bank_state_type   state,
   input  bank_cfg_type     cfg,
   output rsp_payload_type  rsp,
   output bank_state_type   next_state
);

   localparam logic [ROM_CNT_W-1:0] MaxRom = ROM_CNT_W'(MAX_ROM_BANKS);
   localparam logic [RAM_CNT_W-1:0] MaxRam = RAM_CNT_W'(MAX_RAM_BANKS);

   logic [ROM_CNT_W-1:0]  rom_eff;
   logic [RAM_CNT_W-1:0]  ram_eff;
   logic [ROM_LOW_W-1:0]  low_sel;
   logic [UPPER_W-1:0]    up_sel;
   logic [ROM_BANK_W-1:0] cur_rom_bank;
   logic [ROM_BANK_W-1:0] low_try_bank;
   logic [ROM_BANK_W-1:0] up_try_bank;
   logic [UPPER_W-1:0]    ram_bank;
   logic [MAP_W-1:0]      rom_mapped;
   logic [MAP_W-1:0]      ram_mapped;
   logic [MAP_W-1:0]      main_mapped;
   logic [MAP_W-1:0]      dma_mapped;
   logic                  in_rom_sw;
   logic                  in_ram;

   // Counts above the build limits act as the limits.
   assign rom_eff = (cfg.rom_bank_count > MaxRom) ? MaxRom : cfg.rom_bank_count;
   assign ram_eff = (cfg.ram_bank_count > MaxRam) ? MaxRam : cfg.ram_bank_count;

   // Candidate bank values of a control write; a low bank of zero becomes one.
   assign low_sel = (req.write_data[ROM_LOW_W-1:0] == '0) ?
                    ROM_LOW_W'(1) : req.write_data[ROM_LOW_W-1:0];
   assign up_sel  = req.write_data[UPPER_W-1:0];

   // In advanced mode the upper bits select the RAM bank instead of the ROM bank.
   assign cur_rom_bank = state.advanced_mode ? {{UPPER_W{1'b0}}, state.rom_bank_low} :
                                               {state.upper_bank_bits, state.rom_bank_low};
   assign low_try_bank = state.advanced_mode ? {{UPPER_W{1'b0}}, low_sel} :
                                               {state.upper_bank_bits, low_sel};
   assign up_try_bank  = {up_sel, state.rom_bank_low};
   assign ram_bank     = state.advanced_mode ? state.upper_bank_bits : '0;

   // Translated addresses for each region.
   assign rom_mapped  = {cur_rom_bank, req.address[13:0]};
   assign ram_mapped  = {6'b0, ram_bank, req.address[12:0]};
   assign main_mapped = {5'b0, req.address};
   assign dma_mapped  = {5'b0, req.write_data, 8'h00};

   assign in_rom_sw = (req.address >= ADDR_ROM_SW_LO) && (req.address <= ADDR_ROM_SW_HI);
   assign in_ram    = (req.address >= ADDR_RAM_LO) && (req.address <= ADDR_RAM_HI);

   // Classify the access and work out the next bank state.
   always_comb begin
      rsp.region         = REGION_MAIN;
      rsp.mapped_address = '0;
      rsp.forced_data    = '0;
      rsp.bank_error     = 1'b0;
      next_state         = state;

      if (req.func == FUNC_READ) begin
         if (in_rom_sw) begin
            rsp.region         = REGION_ROM;
            rsp.mapped_address = rom_mapped;
         end else if (in_ram) begin
            if (state.ram_enabled) begin
               rsp.region         = REGION_RAM;
               rsp.mapped_address = ram_mapped;
            end else begin
               rsp.region      = REGION_RAM_OFF;
               rsp.forced_data = OPEN_BUS_DATA;
            end
         end else begin
            rsp.mapped_address = main_mapped;
         end
      end else if (req.address <= ADDR_ENABLE_HI) begin
         rsp.region             = REGION_CONTROL;
         next_state.ram_enabled = (req.write_data[3:0] == RAM_ENABLE_KEY) && (ram_eff != '0);
      end else if (req.address <= ADDR_LOW_HI) begin
         rsp.region = REGION_CONTROL;
         if ({1'b0, low_try_bank} >= rom_eff) begin
            rsp.bank_error = 1'b1;
         end else begin
            next_state.rom_bank_low = low_sel;
         end
      end else if (req.address == ADDR_DMA) begin
         rsp.region         = REGION_DMA;
         rsp.mapped_address = dma_mapped;
      end else if (req.address <= ADDR_UPPER_HI) begin
         rsp.region = REGION_CONTROL;
         if (state.advanced_mode) begin
            if ({1'b0, up_sel} < ram_eff) begin
               next_state.upper_bank_bits = up_sel;
            end
         end else if ({1'b0, up_try_bank} >= rom_eff) begin
            rsp.bank_error = 1'b1;
         end else begin
            next_state.upper_bank_bits = up_sel;
         end
      end else if (in_ram) begin
         if (state.ram_enabled) begin
            rsp.region         = REGION_RAM;
            rsp.mapped_address = ram_mapped;
         end else begin
            rsp.region = REGION_RAM_DROP;
         end
      end else if (req.address <= ADDR_ROM_SW_HI) begin
         rsp.region               = REGION_CONTROL;
         next_state.advanced_mode = req.write_data[0] && (rom_eff > ADV_MIN_ROM_BANKS) &&
                                    (ram_eff > ADV_MIN_RAM_BANKS);
      end else begin
         rsp.mapped_address = main_mapped;
      end
   end

endmodule

`default_nettype wire

>>> rtl/rrbm_bank_regs.sv
// Bank state registers and configuration registers with their write port.
`timescale 1ns / 1ps
`default_nettype none

module rrbm_bank_regs
   import rrbm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   rrbm_csr_if.sink         csr_bus,
   input  state_update_type update,
   output bank_state_type   state,
   output bank_cfg_type     cfg
);

   bank_state_type state_ff;
   bank_state_type state_in;
   bank_cfg_type   cfg_ff;
   bank_cfg_type   cfg_in;

   // Register writes are always taken.
   assign csr_bus.ready = 1'b1;

   // Configuration write decode; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_ROM_BANK_COUNT: cfg_in.rom_bank_count = csr_bus.wdata;
            CSR_RAM_BANK_COUNT: cfg_in.ram_bank_count = csr_bus.wdata[RAM_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Bank state follows the decoder whenever an access moves into the result register.
   assign state_in = update.en ? update.next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rom_bank_count    <= 8'd2;
         cfg_ff.ram_bank_count    <= 3'd0;
         state_ff.ram_enabled     <= 1'b0;
         state_ff.rom_bank_low    <= ROM_LOW_W'(1);
         state_ff.upper_bank_bits <= '0;
         state_ff.advanced_mode   <= 1'b0;
      end else begin
         cfg_ff   <= cfg_in;
         state_ff <= state_in;
      end
   end

   assign state = state_ff;
   assign cfg   = cfg_ff;

endmodule

`default_nettype wire

>>> sim/bank_map_checker.sv
// Checker that predicts the bank mapper's results and compares them with the result channel.
`timescale 1ns / 1ps

module bank_map_checker
   import rrbm_pkg::*;
#(
   parameter int MAX_ROM_BANKS = 128,
   parameter int MAX_RAM_BANKS = 4
) (
   input  logic clock,
   input  logic reset,
   rrbm_req_if  req_bus,
   rrbm_rsp_if  rsp_bus,
   rrbm_csr_if  csr_bus,
   output int   fail_count,
   output int   pending,
   output int   checked_count
);

   localparam int ROM_BANK_BYTES  = 'h4000;
   localparam int RAM_BANK_BYTES  = 'h2000;
   localparam int ROM_OFFSET_MASK = 'h3FFF;
   localparam int RAM_OFFSET_MASK = 'h1FFF;
   localparam int ROM_COUNT_RESET = 2;
   localparam int RAM_COUNT_RESET = 0;
   localparam int REPORT_LIMIT    = 10;

   // Shadow copy of the configuration and of the bank registers.
   logic [ROM_CNT_W-1:0] rom_banks;
   logic [RAM_CNT_W-1:0] ram_banks;
   bank_state_type       bank;

   // Results still owed by the block, oldest first.
   rsp_payload_type      owed_results[$];
   int                   mismatches;
   int                   results_seen;

   // Counts above the supported maximum behave as the maximum.
   function automatic int rom_banks_eff();
      return (int'(rom_banks) > MAX_ROM_BANKS) ? MAX_ROM_BANKS : int'(rom_banks);
   endfunction

   function automatic int ram_banks_eff();
      return (int'(ram_banks) > MAX_RAM_BANKS) ? MAX_RAM_BANKS : int'(ram_banks);
   endfunction

   // ROM bank seen by the switched window for given low and upper selects.
   function automatic int rom_bank_index(input int low, input int upper);
      return bank.advanced_mode ? low : ((upper << ROM_LOW_W) | low);
   endfunction

   // Decode one bus access against the shadow state and apply its register update.
   function automatic rsp_payload_type map_access(input req_payload_type acc);
      rsp_payload_type r;
      int              sel;
      int              ram_bank;
      int              addr;
      r        = '0;
      r.region = REGION_MAIN;
      addr     = int'(acc.address);
      ram_bank = bank.advanced_mode ? int'(bank.upper_bank_bits) : 0;
      if (acc.func == FUNC_READ) begin
         if (acc.address >= ADDR_ROM_SW_LO && acc.address <= ADDR_ROM_SW_HI) begin
            r.region = REGION_ROM;
            r.mapped_address = MAP_W'(rom_bank_index(int'(bank.rom_bank_low),
               int'(bank.upper_bank_bits)) * ROM_BANK_BYTES + (addr & ROM_OFFSET_MASK));
         end else if (acc.address >= ADDR_RAM_LO && acc.address <= ADDR_RAM_HI) begin
            if (bank.ram_enabled) begin
               r.region = REGION_RAM;
               r.mapped_address = MAP_W'(ram_bank * RAM_BANK_BYTES + (addr & RAM_OFFSET_MASK));
            end else begin
               r.region = REGION_RAM_OFF;
               r.forced_data = OPEN_BUS_DATA;
            end
         end else begin
            r.mapped_address = MAP_W'(addr);
         end
      end else if (acc.address <= ADDR_ENABLE_HI) begin
         r.region = REGION_CONTROL;
         bank.ram_enabled = (acc.write_data[3:0] == RAM_ENABLE_KEY) && (ram_banks_eff() != 0);
      end else if (acc.address <= ADDR_LOW_HI) begin
         // A zero low select always becomes bank one.
         r.region = REGION_CONTROL;
         sel = int'(acc.write_data[ROM_LOW_W-1:0]);
         if (sel == 0) begin
            sel = 1;
         end
         if (rom_bank_index(sel, int'(bank.upper_bank_bits)) >= rom_banks_eff()) begin
            r.bank_error = 1'b1;
         end else begin
            bank.rom_bank_low = ROM_LOW_W'(sel);
         end
      end else if (acc.address == ADDR_DMA) begin
         r.region = REGION_DMA;
         r.mapped_address = MAP_W'({acc.write_data, 8'h00});
      end else if (acc.address <= ADDR_UPPER_HI) begin
         // Upper bits pick the RAM bank in advanced mode, the high ROM bits otherwise.
         r.region = REGION_CONTROL;
         sel = int'(acc.write_data[UPPER_W-1:0]);
         if (bank.advanced_mode) begin
            if (sel < ram_banks_eff()) begin
               bank.upper_bank_bits = UPPER_W'(sel);
            end
         end else if (rom_bank_index(int'(bank.rom_bank_low), sel) >= rom_banks_eff()) begin
            r.bank_error = 1'b1;
         end else begin
            bank.upper_bank_bits = UPPER_W'(sel);
         end
      end else if (acc.address >= ADDR_RAM_LO && acc.address <= ADDR_RAM_HI) begin
         if (bank.ram_enabled) begin
            r.region = REGION_RAM;
            r.mapped_address = MAP_W'(ram_bank * RAM_BANK_BYTES + (addr & RAM_OFFSET_MASK));
         end else begin
            r.region = REGION_RAM_DROP;
         end
      end else if (acc.address <= ADDR_ROM_SW_HI) begin
         // Advanced mode needs a large ROM and more than one RAM bank.
         r.region = REGION_CONTROL;
         bank.advanced_mode = acc.write_data[0] && (rom_banks_eff() > int'(ADV_MIN_ROM_BANKS))
            && (ram_banks_eff() > int'(ADV_MIN_RAM_BANKS));
      end else begin
         r.mapped_address = MAP_W'(addr);
      end
      return r;
   endfunction

   // Compare one field and report the first few differences.
   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("Mismatch in %s of result %0d: expected 0x%0h, got 0x%0h",
                     field, results_seen, want, got);
         end
      end
   endtask

   // Track register writes, check result beats and record access beats.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rom_banks              = ROM_CNT_W'(ROM_COUNT_RESET);
         ram_banks              = RAM_CNT_W'(RAM_COUNT_RESET);
         bank.ram_enabled       = 1'b0;
         bank.rom_bank_low      = ROM_LOW_W'(1);
         bank.upper_bank_bits   = '0;
         bank.advanced_mode     = 1'b0;
         owed_results.delete();
         mismatches             = 0;
         results_seen           = 0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            if (csr_bus.index == CSR_ROM_BANK_COUNT) begin
               rom_banks = csr_bus.wdata;
            end else if (csr_bus.index == CSR_RAM_BANK_COUNT) begin
               ram_banks = csr_bus.wdata[RAM_CNT_W-1:0];
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (owed_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("Unexpected result beat %0d: region %0d, address 0x%0h",
                           results_seen, rsp_bus.region, rsp_bus.mapped_address);
               end
            end else begin
               want = owed_results.pop_front();
               check_field("region", 32'(want.region), 32'(rsp_bus.region));
               check_field("mapped_address", 32'(want.mapped_address),
                           32'(rsp_bus.mapped_address));
               check_field("forced_data", 32'(want.forced_data), 32'(rsp_bus.forced_data));
               check_field("bank_error", 32'(want.bank_error), 32'(rsp_bus.bank_error));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            owed_results.insert(owed_results.size(),
                                map_access({req_bus.func, req_bus.address,
                                            req_bus.write_data}));
         end
      end
      fail_count    <= mismatches;
      pending       <= owed_results.size();
      checked_count <= results_seen;
   end

endmodule

>>> sim/rom_ram_bank_mapper_top_tb.sv
// Testbench top for the bank mapper: clock, reset, stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module rom_ram_bank_mapper_top_tb;
   import rrbm_pkg::*;

   localparam int ROM_LIMIT     = 128;
   localparam int RAM_LIMIT     = 4;
   localparam int IDLE_PCT      = 22;
   localparam int SETTINGS_N    = 8;
   localparam int RANDOM_SET_N  = 3;
   localparam int PHASE_ITEMS   = 75;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 10;

   logic clock = 1'b0;
   logic reset;

   rrbm_req_if req_bus();
   rrbm_rsp_if rsp_bus();
   rrbm_csr_if csr_bus();

   int fail_count;
   int pending;
   int checked_count;
   int send_idle_pct;
   int recv_stall_pct;
   int sent_count;
   int setting_count;

   // Fixed bank-count settings, extremes and out-of-range values among them.
   int rom_settings [SETTINGS_N] = '{2, 128, 40, 33, 255, 32, 64, 3};
   int ram_settings [SETTINGS_N] = '{0, 4, 3, 2, 7, 4, 1, 1};

   rom_ram_bank_mapper_top #(
      .MAX_ROM_BANKS(ROM_LIMIT),
      .MAX_RAM_BANKS(RAM_LIMIT)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   bank_map_checker #(
      .MAX_ROM_BANKS(ROM_LIMIT),
      .MAX_RAM_BANKS(RAM_LIMIT)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_bus       (csr_bus),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side stalls at random.
   always @(posedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic req_payload_type bus_access(input logic f, input logic [ADDR_W-1:0] a,
                                                  input logic [DATA_W-1:0] d);
      return {f, a, d};
   endfunction

   // Random access, weighted toward the control ranges and the banked windows.
   function automatic req_payload_type random_access();
      req_payload_type acc;
      int              pick;
      pick           = $urandom_range(99);
      acc.func       = FUNC_WRITE;
      acc.write_data = DATA_W'($urandom);
      if (pick < 12) begin
         acc.address = ADDR_W'($urandom_range(0, ADDR_ENABLE_HI));
         if ($urandom_range(1)) begin
            acc.write_data[3:0] = RAM_ENABLE_KEY;
         end
      end else if (pick < 27) begin
         acc.address = ADDR_W'($urandom_range(ADDR_ENABLE_HI + 1, ADDR_LOW_HI));
      end else if (pick < 37) begin
         acc.address = ADDR_W'($urandom_range(ADDR_ROM_SW_LO, ADDR_UPPER_HI));
      end else if (pick < 43) begin
         acc.address = ADDR_W'($urandom_range(ADDR_UPPER_HI + 1, ADDR_ROM_SW_HI));
      end else if (pick < 63) begin
         acc.func    = FUNC_READ;
         acc.address = ADDR_W'($urandom_range(ADDR_ROM_SW_LO, ADDR_ROM_SW_HI));
      end else if (pick < 80) begin
         acc.func    = $urandom_range(1) ? FUNC_WRITE : FUNC_READ;
         acc.address = ADDR_W'($urandom_range(ADDR_RAM_LO, ADDR_RAM_HI));
      end else if (pick < 84) begin
         acc.address = ADDR_DMA;
      end else if (pick < 92) begin
         acc.func    = FUNC_READ;
         acc.address = ADDR_W'($urandom_range(0, ADDR_LOW_HI));
      end else begin
         acc.func    = $urandom_range(1) ? FUNC_WRITE : FUNC_READ;
         acc.address = ADDR_W'($urandom);
      end
      return acc;
   endfunction

   // Drive one access beat; valid stays high until the next idle or pause.
   task automatic send_access(input req_payload_type acc);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.func       <= acc.func;
      req_bus.address    <= acc.address;
      req_bus.write_data <= acc.write_data;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      sent_count++;
   endtask

   // Stop sending and wait until every owed result has come back.
   task automatic wait_drained(input int settle);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (settle) @(posedge clock);
   endtask

   // Write both bank counts as two back-to-back register beats.
   task automatic write_bank_counts(input int rom_count, input int ram_count);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= CSR_ROM_BANK_COUNT;
      csr_bus.wdata <= DATA_W'(rom_count);
      @(posedge clock);
      while (!csr_bus.ready) begin
         @(posedge clock);
      end
      csr_bus.index <= CSR_RAM_BANK_COUNT;
      csr_bus.wdata <= DATA_W'(ram_count);
      @(posedge clock);
      while (!csr_bus.ready) begin
         @(posedge clock);
      end
      csr_bus.valid <= 1'b0;
      setting_count++;
   endtask

   // Stimulus and verdict.
   initial begin
      req_payload_type directed [$];
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.func       <= FUNC_READ;
      req_bus.address    <= '0;
      req_bus.write_data <= '0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= CSR_ROM_BANK_COUNT;
      csr_bus.wdata      <= '0;
      send_idle_pct       = IDLE_PCT;
      recv_stall_pct      = IDLE_PCT;
      sent_count          = 0;
      setting_count       = 1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // A short random run on the reset bank counts.
      repeat (40) send_access(random_access());
      wait_drained(SETTLE_CYCLES);

      // Directed accesses with 40 ROM banks and 3 RAM banks.
      write_bank_counts(40, 3);
      directed = '{
         bus_access(FUNC_READ,  16'h0000, 8'h00),
         bus_access(FUNC_READ,  16'hFFFF, 8'hFF),
         bus_access(FUNC_READ,  ADDR_ROM_SW_LO, 8'h00),
         bus_access(FUNC_WRITE, 16'h2000, 8'h00),
         bus_access(FUNC_WRITE, ADDR_LOW_HI, 8'hFF),
         bus_access(FUNC_READ,  ADDR_ROM_SW_HI, 8'h00),
         bus_access(FUNC_WRITE, ADDR_ROM_SW_LO, 8'h01),
         bus_access(FUNC_WRITE, 16'h2000, 8'h07),
         bus_access(FUNC_WRITE, ADDR_UPPER_HI, 8'h01),
         bus_access(FUNC_WRITE, 16'h2000, 8'h08),
         bus_access(FUNC_READ,  16'h4123, 8'h00),
         bus_access(FUNC_READ,  ADDR_RAM_LO, 8'h00),
         bus_access(FUNC_WRITE, ADDR_RAM_HI, 8'hAA),
         bus_access(FUNC_WRITE, 16'h0000, 8'h0A),
         bus_access(FUNC_READ,  ADDR_RAM_HI, 8'h00),
         bus_access(FUNC_WRITE, ADDR_RAM_LO, 8'h55),
         bus_access(FUNC_WRITE, ADDR_DMA, 8'hFF),
         bus_access(FUNC_WRITE, ADDR_DMA, 8'h00),
         bus_access(FUNC_WRITE, 16'h6000, 8'h01),
         bus_access(FUNC_WRITE, ADDR_ROM_SW_LO, 8'h02),
         bus_access(FUNC_WRITE, ADDR_ROM_SW_LO, 8'h03),
         bus_access(FUNC_READ,  16'hA123, 8'h00),
         bus_access(FUNC_READ,  ADDR_ROM_SW_LO, 8'h00),
         bus_access(FUNC_WRITE, ADDR_ROM_SW_HI, 8'h00),
         bus_access(FUNC_WRITE, ADDR_ENABLE_HI, 8'h1F),
         bus_access(FUNC_WRITE, 16'hC000, 8'h3C)
      };
      foreach (directed[i]) begin
         send_access(directed[i]);
      end
      wait_drained(SETTLE_CYCLES);

      // Random runs over fixed and random bank-count settings; one runs without any idling.
      for (int p = 0; p < SETTINGS_N + RANDOM_SET_N; p++) begin
         if (p < SETTINGS_N) begin
            write_bank_counts(rom_settings[p], ram_settings[p]);
         end else begin
            write_bank_counts($urandom_range(2, 255), $urandom_range(0, 7));
         end
         send_idle_pct  = (p == 1) ? 0 : IDLE_PCT;
         recv_stall_pct = (p == 1) ? 0 : IDLE_PCT;
         repeat (PHASE_ITEMS) send_access(random_access());
         wait_drained(SETTLE_CYCLES);
      end

      wait_drained(DRAIN_CYCLES);
      $display("Sent %0d bus accesses and checked %0d results across %0d bank-count settings,",
               sent_count, checked_count, setting_count);
      $display("covering control writes, bank errors, both banking modes, RAM and DMA accesses.");
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches found.", fail_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog against a hung handshake or results that never arrive.
   initial begin
      #3_000_000;
      $display("Timeout with %0d results still owed.", pending);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
